// File: src/assert_macros.svh
// Assertion helper macros shared by the click generator RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, disabled in reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/mcg_pkg.sv
// Package for the metronome click generator: payload structs, codes, tables.
// No dependencies.
`timescale 1ns / 1ps
package mcg_pkg;

  typedef struct packed {
    logic signed [15:0] in_left;
    logic signed [15:0] in_right;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
  } out_word_t;

  // configuration register indexes
  localparam logic [2:0] REG_ENABLE  = 3'd0;
  localparam logic [2:0] REG_QPERIOD = 3'd1;
  localparam logic [2:0] REG_SUB_A   = 3'd2;
  localparam logic [2:0] REG_SUB_B   = 3'd3;
  localparam logic [2:0] REG_BPB     = 3'd4;
  localparam logic [2:0] REG_VOICE   = 3'd5;
  localparam logic [2:0] REG_GAIN_A  = 3'd6;
  localparam logic [2:0] REG_GAIN_B  = 3'd7;

  // subdivision codes
  localparam logic [2:0] SUB_WHOLE   = 3'd0;
  localparam logic [2:0] SUB_HALF    = 3'd1;
  localparam logic [2:0] SUB_QUARTER = 3'd2;
  localparam logic [2:0] SUB_EIGHTH  = 3'd3;
  localparam logic [2:0] SUB_SIXTNTH = 3'd4;
  localparam logic [2:0] SUB_TRIPLET = 3'd5;
  localparam logic [2:0] SUB_SILENT  = 3'd6;

  localparam logic [23:0] ENV_ONE  = 24'd8388608;
  localparam logic [23:0] ENV_STOP = 24'd8389;

  // ALU operation codes
  typedef enum logic [1:0] {
    OP_MUL_ENV  = 2'd0,   // sine * envelope
    OP_MUL_GAIN = 2'd1,   // (sine*env) * gain, full 38-bit operand
    OP_MUL_DEC  = 2'd2    // envelope * decay multiplier
  } alu_op_t;

  // control from sequencer to datapath unit
  typedef struct packed {
    alu_op_t     op;
    logic [39:0] a;
    logic [23:0] b;
  } alu_req_t;

endpackage

// File: src/mcg_sine_rom.sv
// Sine lookup with registered read data, Q1.15, quarter-wave symmetric.
// Depends on mcg_pkg. Table built at elaboration.
`timescale 1ns / 1ps
module mcg_sine_rom
  import mcg_pkg::*;
#(
  parameter int TABLE_SIZE = 1024
) (
  input  logic                          clk,
  input  logic [$clog2(TABLE_SIZE)-1:0] addr,
  output logic signed [15:0]            data
);

  localparam int AW = $clog2(TABLE_SIZE);

  // evaluate the series sine the same way as the fixed-point spec
  function automatic logic signed [15:0] sine_entry(input longint unsigned i);
    longint unsigned ph, quad, w, x, x2, t, s, r;
    ph   = (i << 32) / TABLE_SIZE;
    quad = ph >> 30;
    w    = ph & 64'h3FFF_FFFF;
    if (quad[0]) w = (64'd1 << 30) - w;
    x  = (w * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t  = (64'd1 << 30) - x2 / 72;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    r  = (s + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    sine_entry = quad[1] ? -16'(r) : 16'(r);
  endfunction

  logic signed [15:0] rom [TABLE_SIZE];

  always_comb begin
    for (int k = 0; k < TABLE_SIZE; k++) rom[k] = sine_entry(longint'(k));
  end

  always_ff @(posedge clk) begin
    data <= rom[addr];
  end

  logic unused_aw;
  assign unused_aw = (AW > 0);

endmodule

// File: src/mcg_mul_unit.sv
// Shared registered multiplier for the click sequencer.
// Depends on mcg_pkg.
`timescale 1ns / 1ps
module mcg_mul_unit
  import mcg_pkg::*;
(
  input  logic        clk,
  input  alu_req_t    req,
  output logic [63:0] prod_r
);

  logic [63:0] prod_nxt;

  // one product per cycle, operand shapes chosen per op (at most 38x16 or 24x24)
  always_comb begin
    unique case (req.op)
      OP_MUL_ENV:  prod_nxt = {24'd0, 40'(req.a[15:0] * req.b)};
      OP_MUL_GAIN: prod_nxt = {10'd0, 54'(req.a[37:0] * req.b[15:0])};
      OP_MUL_DEC:  prod_nxt = {16'd0, 48'(req.a[23:0] * req.b)};
      default:     prod_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// File: src/metronome_click_generator_unit.sv
// Metronome click generator top level: sequencer, state and mixer.
// Depends on mcg_pkg, mcg_sine_rom, mcg_mul_unit, assert_macros.svh.
// Sequence: S_MIX, S_OUT if disabled; if enabled, S_CNT for each channel, then
// S_ROM, S_M1, S_M2, S_M3, S_ACC per channel, S_MIX and S_OUT (held by out_stall).
// Inputs wait for S_IDLE; one multiplier is reused for three products per channel.
// Reset: synchronous active-low; config to defaults, click state cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module metronome_click_generator_unit
  import mcg_pkg::*;
#(
  parameter int SAMPLE_RATE      = 48000,
  parameter int SINE_TABLE_SIZE  = 1024,
  parameter int PERIOD_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [25:0] cfg_data
);

  localparam int AW = $clog2(SINE_TABLE_SIZE);
  localparam int CW = 30;
  localparam logic signed [CW-1:0] ONE_SAMPLE = CW'(1) <<< PERIOD_FRAC_BITS;

  function automatic logic [31:0] voice_inc(input logic [2:0] v);
    longint unsigned f;
    unique case (v)
      3'd0: f = 880;
      3'd1: f = 1500;
      3'd2: f = 540;
      3'd3: f = 1200;
      3'd4: f = 2200;
      default: f = 1000;
    endcase
    voice_inc = 32'(((f << 32) + SAMPLE_RATE / 2) / SAMPLE_RATE);
  endfunction

  function automatic logic [23:0] voice_mul(input logic [2:0] v);
    longint unsigned d, y, y2, y3, e;
    unique case (v)
      3'd0: d = 30;
      3'd1: d = 80;
      3'd2: d = 18;
      3'd3: d = 100;
      3'd4: d = 140;
      default: d = 60;
    endcase
    y  = ((d << 30) + SAMPLE_RATE / 2) / SAMPLE_RATE;
    y2 = (y * y) >> 30;
    y3 = (y2 * y) >> 30;
    e  = (64'd1 << 30) - y + y2 / 2 - y3 / 6;
    voice_mul = 24'((e + 64'd32) >> 6);
  endfunction

  // per-voice phase step and decay multiplier, fixed at elaboration
  localparam logic [7:0][31:0] INC_TAB = {
    voice_inc(3'd7), voice_inc(3'd6), voice_inc(3'd5), voice_inc(3'd4),
    voice_inc(3'd3), voice_inc(3'd2), voice_inc(3'd1), voice_inc(3'd0)
  };
  localparam logic [7:0][23:0] MUL_TAB = {
    voice_mul(3'd7), voice_mul(3'd6), voice_mul(3'd5), voice_mul(3'd4),
    voice_mul(3'd3), voice_mul(3'd2), voice_mul(3'd1), voice_mul(3'd0)
  };

  // configuration registers
  logic        enable_r;
  logic [25:0] qper_r;
  logic [2:0]  sub_r [2];
  logic [6:0]  bpb_r;
  logic [5:0]  voice_pair_r;
  logic [15:0] gain_cfg_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b0;
      qper_r        <= 26'd6144000;
      sub_r[0]      <= SUB_QUARTER;
      sub_r[1]      <= SUB_QUARTER;
      bpb_r         <= 7'd4;
      voice_pair_r  <= '0;
      gain_cfg_r[0] <= 16'd16384;
      gain_cfg_r[1] <= 16'd16384;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:  enable_r      <= cfg_data[0];
        REG_QPERIOD: qper_r        <= cfg_data;
        REG_SUB_A:   sub_r[0]      <= cfg_data[2:0];
        REG_SUB_B:   sub_r[1]      <= cfg_data[2:0];
        REG_BPB:     bpb_r         <= cfg_data[6:0];
        REG_VOICE:   voice_pair_r  <= cfg_data[5:0];
        REG_GAIN_A:  gain_cfg_r[0] <= cfg_data[15:0];
        REG_GAIN_B:  gain_cfg_r[1] <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer states, one-hot
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_CNT  = 9'b000000010,
    S_ROM  = 9'b000000100,
    S_M1   = 9'b000001000,
    S_M2   = 9'b000010000,
    S_M3   = 9'b000100000,
    S_ACC  = 9'b001000000,
    S_MIX  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   ch_r, ch_nxt;

  // click state per channel
  logic signed [CW-1:0] cnt_r [2];
  logic [5:0]  beat_r [2];
  logic [31:0] phase_r [2];
  logic [23:0] env_r [2];
  logic        act_r [2];
  logic [2:0]  voice_r [2];
  logic [15:0] bgain_r [2];

  in_word_t    smp_r;
  out_word_t   res_r;
  logic        out_valid_r;
  logic signed [18:0] sum_r;
  logic signed [15:0] sine_q;
  logic [AW-1:0]      rom_addr;
  logic               neg_r;
  logic [16:0]        mag_r;
  logic [63:0]        prod;
  alu_req_t           req;

  mcg_sine_rom #(.TABLE_SIZE(SINE_TABLE_SIZE)) u_rom (
    .clk(clk), .addr(rom_addr), .data(sine_q)
  );
  mcg_mul_unit u_mul (.clk(clk), .req(req), .prod_r(prod));

  // table index = (phase * size) >> 32
  assign rom_addr = AW'((64'(phase_r[ch_r]) * 64'(SINE_TABLE_SIZE)) >> 32);

  // multiplier operand select
  always_comb begin
    req.op = OP_MUL_ENV;
    req.a  = {24'd0, (sine_q < 0) ? 16'(-sine_q) : 16'(sine_q)};
    req.b  = env_r[ch_r];
    if (state_r == S_M2) begin
      req.op = OP_MUL_GAIN;
      req.a  = prod[39:0];
      req.b  = {8'd0, bgain_r[ch_r]};
    end else if (state_r == S_M3) begin
      req.op = OP_MUL_DEC;
      req.a  = {16'd0, env_r[ch_r]};
      req.b  = MUL_TAB[voice_r[ch_r]];
    end
  end

  // click period for a mode, clamped to one sample
  function automatic logic signed [CW-1:0] click_period(input logic [2:0] m,
                                                        input logic [25:0] q);
    logic [CW-1:0] p;
    unique case (m)
      SUB_WHOLE:   p = {q, 2'b00} + {CW{1'b0}};
      SUB_HALF:    p = {1'b0, q, 1'b0} + {CW{1'b0}};
      SUB_EIGHTH:  p = CW'(q >> 1);
      SUB_SIXTNTH: p = CW'(q >> 2);
      SUB_TRIPLET: p = CW'((54'(q) * 54'd89478486) >> 28);
      default:     p = CW'(q);
    endcase
    if (p < CW'(ONE_SAMPLE)) p = CW'(ONE_SAMPLE);
    click_period = p;
  endfunction

  logic [6:0] bpb_eff;
  assign bpb_eff = (bpb_r == 7'd0) ? 7'd1 : ((bpb_r > 7'd64) ? 7'd64 : bpb_r);

  logic signed [CW-1:0] cnt_dec;
  logic                 fire;
  assign cnt_dec = cnt_r[ch_r] - ONE_SAMPLE;
  assign fire = ch_r ? !(sub_r[1] == SUB_QUARTER && beat_r[1] == 6'd0)
                     : (beat_r[0] == 6'd0);

  // signed click value before accumulation
  logic signed [17:0] click_val;
  assign click_val = neg_r ? -18'(mag_r) : 18'(mag_r);

  logic signed [19:0] mixl, mixr;
  assign mixl = 20'(smp_r.in_left)  + 20'(sum_r);
  assign mixr = 20'(smp_r.in_right) + 20'(sum_r);

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767)       sat16 = 16'sd32767;
    else if (v < -20'sd32768) sat16 = -16'sd32768;
    else                      sat16 = v[15:0];
  endfunction

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = enable_r ? S_CNT : S_MIX;
      S_CNT:  begin
        ch_nxt = ~ch_r;
        if (ch_r) state_nxt = S_ROM;
      end
      S_ROM:  state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_ACC;
      S_ACC:  begin
        ch_nxt = ~ch_r;
        state_nxt = ch_r ? S_MIX : S_ROM;
      end
      S_MIX:  state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        cnt_r[c] <= '0; beat_r[c] <= '0; phase_r[c] <= '0;
        env_r[c] <= '0; act_r[c] <= 1'b0; voice_r[c] <= '0; bgain_r[c] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      // load a new word once the output register is free, hold it while stalled
      out_valid_r <= (state_r == S_OUT && (!out_valid_r || !out_stall))
                     || (out_valid_r && out_stall);
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          smp_r <= in_data;
          sum_r <= '0;
        end
        S_CNT: if (sub_r[ch_r] != SUB_SILENT) begin
          if (cnt_dec > 0) cnt_r[ch_r] <= cnt_dec;
          else begin
            cnt_r[ch_r] <= cnt_dec + click_period(sub_r[ch_r], qper_r);
            if (fire) begin
              phase_r[ch_r] <= '0;
              env_r[ch_r]   <= ENV_ONE;
              act_r[ch_r]   <= 1'b1;
              voice_r[ch_r] <= ch_r ? voice_pair_r[5:3] : voice_pair_r[2:0];
              bgain_r[ch_r] <= gain_cfg_r[ch_r];
            end
            beat_r[ch_r] <= (7'(beat_r[ch_r]) + 7'd1 >= bpb_eff) ? 6'd0
                                                                 : beat_r[ch_r] + 6'd1;
          end
        end
        S_M1: neg_r <= sine_q[15];
        // keep the gain product; the multiplier moves on to the decay
        S_M3: mag_r <= prod[53:37];
        S_ACC: if (act_r[ch_r]) begin
          sum_r <= sum_r + 19'(click_val);
          phase_r[ch_r] <= phase_r[ch_r] + INC_TAB[voice_r[ch_r]];
          if (env_r[ch_r] < ENV_STOP) act_r[ch_r] <= 1'b0;
          env_r[ch_r] <= prod[47:24];
        end
        // result register written only when it is free
        S_OUT: if (!out_valid_r || !out_stall) begin
          res_r.out_left  <= enable_r ? sat16(mixl) : smp_r.in_left;
          res_r.out_right <= enable_r ? sat16(mixr) : smp_r.in_right;
        end
        default: ;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  `ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_r))
  `ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, in_valid && !in_stall, state_r != S_IDLE)
  `ASSERT_NXT(a_out_after_seq, clk, rst_n,
              state_r == S_OUT && (!out_valid_r || !out_stall), out_valid_r)

endmodule
